// ===== sv/gha_pkg.sv =====
package gha_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int GEN_BITS   = 16;

   localparam int INDEX_W = $clog2(SLOT_COUNT);
   localparam int COUNT_W = $clog2(SLOT_COUNT + 1);

   localparam int SLOT_INDEX_W   = 10;
   localparam int HANDLE_GEN_W   = 16;

   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [GEN_BITS-1:0] gen_type;

   typedef logic [SLOT_INDEX_W-1:0] slot_field_type;
   typedef logic [HANDLE_GEN_W-1:0] gen_field_type;

   typedef enum logic {
      CMD_CREATE  = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SLOT    = 2'd1,
      STATUS_NOT_OPENED = 2'd2,
      STATUS_QUEUE_FULL = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type        cmd;
      slot_field_type slot_index;
   } req_type;

   typedef struct packed {
      status_type     status;
      slot_field_type handle_index;
      gen_field_type  handle_generation;
   } rsp_type;

endpackage

// ===== sv/generational_handle_allocator.sv =====
// A fresh create or a rejected request is answered straight from ST_IDLE into the
// response register; a release goes through ST_GEN_RD, and a create that reuses a queued
// slot through ST_QUEUE_RD (free queue memory read) and then ST_GEN_RD (read-modify-write
// of the generation memory). A new request is taken only in ST_IDLE with the response
// register free. Reset clears the counters and pointers; there is no clearing pass, since
// generation entries above the high-water mark are written before they are ever read.
module generational_handle_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gha_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUEUE_RD,
      ST_GEN_RD
   } state_type;

   localparam gha_pkg::index_type LAST_SLOT  = gha_pkg::index_type'(gha_pkg::SLOT_COUNT - 1);
   localparam gha_pkg::count_type FULL_COUNT = gha_pkg::count_type'(gha_pkg::SLOT_COUNT);

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gha_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;
   gha_pkg::index_type free_head_ff, free_head_in;
   gha_pkg::index_type free_tail_ff, free_tail_in;
   gha_pkg::count_type free_count_ff, free_count_in;
   gha_pkg::count_type slots_opened_ff, slots_opened_in;
   logic               release_ff, release_in;
   gha_pkg::index_type slot_ff, slot_in;

   logic               out_free;
   gha_pkg::index_type req_slot;

   logic               gen_wr_en;
   gha_pkg::index_type gen_wr_addr;
   gha_pkg::gen_type   gen_wr_data;
   logic               gen_rd_en;
   gha_pkg::index_type gen_rd_addr;
   gha_pkg::gen_type   gen_rd_data;
   gha_pkg::gen_type   gen_next;

   logic               q_wr_en;
   logic               q_rd_en;
   gha_pkg::index_type q_rd_data;

   gha_ram #(
      .WIDTH (gha_pkg::GEN_BITS),
      .DEPTH (gha_pkg::SLOT_COUNT)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   gha_ram #(
      .WIDTH (gha_pkg::INDEX_W),
      .DEPTH (gha_pkg::SLOT_COUNT)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (free_tail_ff),
      .wr_data (slot_ff),
      .rd_en   (q_rd_en),
      .rd_addr (free_head_ff),
      .rd_data (q_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_slot  = gha_pkg::index_type'(req_payload.slot_index);
   assign gen_next  = gen_rd_data + gha_pkg::gen_type'(1);

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      free_head_in    = free_head_ff;
      free_tail_in    = free_tail_ff;
      free_count_in   = free_count_ff;
      slots_opened_in = slots_opened_ff;
      release_in      = release_ff;
      slot_in         = slot_ff;
      gen_wr_en       = 1'b0;
      gen_wr_addr     = slot_ff;
      gen_wr_data     = gen_next;
      gen_rd_en       = 1'b0;
      gen_rd_addr     = slot_ff;
      q_wr_en         = 1'b0;
      q_rd_en         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_payload.cmd == gha_pkg::CMD_CREATE) begin
                  release_in = 1'b0;
                  if (free_count_ff != '0) begin
                     q_rd_en  = 1'b1;
                     state_in = ST_QUEUE_RD;
                  end else if (slots_opened_ff == FULL_COUNT) begin
                     rsp_valid_in                     = 1'b1;
                     rsp_payload_in.status            = gha_pkg::STATUS_NO_SLOT;
                     rsp_payload_in.handle_index      = '0;
                     rsp_payload_in.handle_generation = '0;
                  end else begin
                     // A fresh slot starts at generation one; its old contents are never read.
                     gen_wr_en       = 1'b1;
                     gen_wr_addr     = slots_opened_ff[gha_pkg::INDEX_W-1:0];
                     gen_wr_data     = gha_pkg::gen_type'(1);
                     slots_opened_in = slots_opened_ff + gha_pkg::count_type'(1);
                     rsp_valid_in    = 1'b1;
                     rsp_payload_in.status       = gha_pkg::STATUS_OK;
                     rsp_payload_in.handle_index =
                        gha_pkg::slot_field_type'(slots_opened_ff[gha_pkg::INDEX_W-1:0]);
                     rsp_payload_in.handle_generation =
                        gha_pkg::gen_field_type'(gha_pkg::gen_type'(1));
                  end
               end else begin
                  release_in = 1'b1;
                  if (gha_pkg::count_type'(req_slot) >= slots_opened_ff) begin
                     rsp_valid_in                     = 1'b1;
                     rsp_payload_in.status            = gha_pkg::STATUS_NOT_OPENED;
                     rsp_payload_in.handle_index      = req_payload.slot_index;
                     rsp_payload_in.handle_generation = '0;
                  end else if (free_count_ff == FULL_COUNT) begin
                     rsp_valid_in                     = 1'b1;
                     rsp_payload_in.status            = gha_pkg::STATUS_QUEUE_FULL;
                     rsp_payload_in.handle_index      = req_payload.slot_index;
                     rsp_payload_in.handle_generation = '0;
                  end else begin
                     slot_in     = req_slot;
                     gen_rd_en   = 1'b1;
                     gen_rd_addr = req_slot;
                     state_in    = ST_GEN_RD;
                  end
               end
            end
         end
         ST_QUEUE_RD: begin
            slot_in       = q_rd_data;
            gen_rd_en     = 1'b1;
            gen_rd_addr   = q_rd_data;
            free_head_in  = (free_head_ff == LAST_SLOT) ? '0
                                                        : free_head_ff + gha_pkg::index_type'(1);
            free_count_in = free_count_ff - gha_pkg::count_type'(1);
            state_in      = ST_GEN_RD;
         end
         ST_GEN_RD: begin
            // The read data holds while the response register is still occupied.
            if (out_free) begin
               gen_wr_en = 1'b1;
               if (release_ff) begin
                  q_wr_en       = 1'b1;
                  free_tail_in  = (free_tail_ff == LAST_SLOT) ? '0
                                                              : free_tail_ff + gha_pkg::index_type'(1);
                  free_count_in = free_count_ff + gha_pkg::count_type'(1);
               end
               rsp_valid_in                     = 1'b1;
               rsp_payload_in.status            = gha_pkg::STATUS_OK;
               rsp_payload_in.handle_index      = gha_pkg::slot_field_type'(slot_ff);
               rsp_payload_in.handle_generation = gha_pkg::gen_field_type'(gen_next);
               state_in                         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         free_head_ff    <= '0;
         free_tail_ff    <= '0;
         free_count_ff   <= '0;
         slots_opened_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         free_head_ff    <= free_head_in;
         free_tail_ff    <= free_tail_in;
         free_count_ff   <= free_count_in;
         slots_opened_ff <= slots_opened_in;
      end
      rsp_payload_ff <= rsp_payload_in;
      release_ff     <= release_in;
      slot_ff        <= slot_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FULL_COUNT && slots_opened_ff <= FULL_COUNT)
      else $error("free count or high-water mark beyond slot count");

   a_ring_empty_full: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff == '0 || free_count_ff == FULL_COUNT) |-> free_head_ff == free_tail_ff)
      else $error("free queue pointers disagree with count");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE || rsp_valid_ff))
      else $error("accepted request neither in progress nor answered");

   a_gen_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_RD && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("generation update did not produce a response");

   a_queue_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUEUE_RD |-> free_count_ff != '0)
      else $error("free queue read while empty");

endmodule

// ===== sv/gha_ram.sv =====
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
